// ----- hdl/lld_pkg.sv -----
// ----------------------------------------------------------------------------
// lld_pkg: shared types and constants for the 3D line-line distance engine
// Field widths of the request, the job handed from front to back, and the
// register map of the control port.
// ----------------------------------------------------------------------------
package lld_pkg;

   localparam int COORD_W  = 32;   // input coordinate width
   localparam int THR_W    = 48;   // parallel threshold register width
   localparam int DIST_W   = 34;   // distance result width
   localparam int MAG_W    = 64;   // magnitude of n_i, c_i (|n_i| < 2^63, |c_i| < 2^64)
   localparam int WMAG_W   = 33;   // magnitude of w_i
   localparam int EMAG_W   = 97;   // magnitude of w.n (< 3 * 2^95)
   localparam int CNUM_W   = 130;  // |w x db|^2
   localparam int DEN_W    = 128;  // |n|^2 or |db|^2
   localparam int NUM_W    = 2 * EMAG_W;
   localparam int Q_W      = DEN_W + DIST_W;
   localparam int T_W      = Q_W + DIST_W + 1;

   localparam int CSR_DW   = 64;
   localparam int CSR_AW   = 4;
   localparam logic CSR_IDX_THR = 1'b0;  // register index, taken from paddr[CSR_AW-1]

   localparam int FIFO_DEPTH = 2;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] pa_x;
      logic signed [COORD_W-1:0] pa_y;
      logic signed [COORD_W-1:0] pa_z;
      logic signed [COORD_W-1:0] da_x;
      logic signed [COORD_W-1:0] da_y;
      logic signed [COORD_W-1:0] da_z;
      logic signed [COORD_W-1:0] pb_x;
      logic signed [COORD_W-1:0] pb_y;
      logic signed [COORD_W-1:0] pb_z;
      logic signed [COORD_W-1:0] db_x;
      logic signed [COORD_W-1:0] db_y;
      logic signed [COORD_W-1:0] db_z;
   } lld_req_type;

   // distance = floor(sqrt(num / den)), saturated to DIST_W bits
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             is_parallel;
      logic             degenerate;
   } lld_job_type;

endpackage

// ----- hdl/line_line_distance_3d.sv -----
// ----------------------------------------------------------------------------
// line_line_distance_3d: shortest distance between two 3D lines
// Point/direction pairs in signed fixed point in, floor distance out.
// ----------------------------------------------------------------------------
// Usage: pulse start with the twelve req_ fields while busy is low; one
// transaction is taken per clock. Each transaction yields exactly one result,
// shown for one cycle with rsp_strobe high, in request order. The receiver
// cannot hold results off, so capture them on the strobe. A request passes
// through the front pipeline, the job queue and the root pipeline before its
// result strobe. The rate is one transaction per clock; it is set by the
// fully pipelined front end (one 32x32 partial product per multiplier
// stage) and the 34-stage root unit, and busy only rises if the job queue
// ever fills.
// Math: w = pa - pb, n = da x db. If |n|^2 <= threshold * 2^(3*frac) the
// pair counts as parallel and the distance is |w x db| / |db| (degenerate,
// distance 0, when da.db is 0); otherwise it is |w.n| / |n|. The result is
// the floor of the exact value, saturating at all ones.
// Register 0 (byte address 0, 64-bit data): parallel threshold, 48 bits.
// Change it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module line_line_distance_3d #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [lld_pkg::COORD_W-1:0]   req_pa_x,
   input  logic [lld_pkg::COORD_W-1:0]   req_pa_y,
   input  logic [lld_pkg::COORD_W-1:0]   req_pa_z,
   input  logic [lld_pkg::COORD_W-1:0]   req_da_x,
   input  logic [lld_pkg::COORD_W-1:0]   req_da_y,
   input  logic [lld_pkg::COORD_W-1:0]   req_da_z,
   input  logic [lld_pkg::COORD_W-1:0]   req_pb_x,
   input  logic [lld_pkg::COORD_W-1:0]   req_pb_y,
   input  logic [lld_pkg::COORD_W-1:0]   req_pb_z,
   input  logic [lld_pkg::COORD_W-1:0]   req_db_x,
   input  logic [lld_pkg::COORD_W-1:0]   req_db_y,
   input  logic [lld_pkg::COORD_W-1:0]   req_db_z,
   // result channel
   output logic                          rsp_strobe,
   output logic [lld_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_is_parallel,
   output logic                          rsp_degenerate,
   // control port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lld_pkg::CSR_AW-1:0]    paddr,
   input  logic [lld_pkg::CSR_DW-1:0]    pwdata,
   output logic [lld_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);
   import lld_pkg::*;

   // ---- control register
   logic [THR_W-1:0] thr_ff;
   logic             csr_hit;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_AW-1] == CSR_IDX_THR);
   assign prdata  = csr_hit ? CSR_DW'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         thr_ff <= pwdata[THR_W-1:0];
      end
   end

   // ---- request bundle
   lld_req_type req;

   always_comb begin
      req.pa_x = req_pa_x;
      req.pa_y = req_pa_y;
      req.pa_z = req_pa_z;
      req.da_x = req_da_x;
      req.da_y = req_da_y;
      req.da_z = req_da_z;
      req.pb_x = req_pb_x;
      req.pb_y = req_pb_y;
      req.pb_z = req_pb_z;
      req.db_x = req_db_x;
      req.db_y = req_db_y;
      req.db_z = req_db_z;
   end

   // ---- front end -> queue -> root unit
   logic        job_valid;
   lld_job_type job;
   logic        fifo_full;
   logic        fifo_valid;
   lld_job_type fifo_data;

   lld_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .thr       (thr_ff),
      .fifo_full (fifo_full),
      .busy      (busy),
      .job_valid (job_valid),
      .job       (job)
   );

   // root pipeline never stalls, so the queue drains every cycle it holds a job
   lld_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (job_valid),
      .wdata (job),
      .pop   (fifo_valid),
      .full  (fifo_full),
      .valid (fifo_valid),
      .rdata (fifo_data)
   );

   lld_root u_root (
      .clock           (clock),
      .reset           (reset),
      .job_v           (fifo_valid),
      .job             (fifo_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_distance    (rsp_distance),
      .rsp_is_parallel (rsp_is_parallel),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule

// ----- hdl/lld_mul.sv -----
// ----------------------------------------------------------------------------
// lld_mul: pipelined unsigned multiplier
// One 32x32 partial product per stage, accumulated along the pipe, with a
// valid bit and a sideband word carried at the same latency.
// ----------------------------------------------------------------------------
module lld_mul #(
   parameter int W  = 64,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_v,
   input  logic [W-1:0]    a,
   input  logic [W-1:0]    b,
   input  logic [SW-1:0]   side_in,
   output logic            out_v,
   output logic [2*W-1:0]  p,
   output logic [SW-1:0]   side_out
);
   localparam int LW = 32;
   localparam int NC = (W + LW - 1) / LW;
   localparam int NS = NC * NC;
   localparam int PW = NC * LW;
   localparam int AW = 2 * PW;

   logic          v_ff    [NS];
   logic [PW-1:0] a_ff    [NS];
   logic [PW-1:0] b_ff    [NS];
   logic [AW-1:0] acc_ff  [NS];
   logic [SW-1:0] side_ff [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int I = s / NC;
      localparam int J = s % NC;
      logic          v_src;
      logic [PW-1:0] a_src;
      logic [PW-1:0] b_src;
      logic [AW-1:0] acc_src;
      logic [SW-1:0] side_src;
      logic [2*LW-1:0] pp;
      logic [AW-1:0] acc_in;

      if (s == 0) begin : g_head
         assign v_src    = in_v;
         assign a_src    = PW'(a);
         assign b_src    = PW'(b);
         assign acc_src  = '0;
         assign side_src = side_in;
      end else begin : g_body
         assign v_src    = v_ff[s-1];
         assign a_src    = a_ff[s-1];
         assign b_src    = b_ff[s-1];
         assign acc_src  = acc_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      assign pp     = a_src[I*LW +: LW] * b_src[J*LW +: LW];
      assign acc_in = acc_src + (AW'(pp) << (LW * (I + J)));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[s]    <= a_src;
            b_ff[s]    <= b_src;
            acc_ff[s]  <= acc_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_v    = v_ff[NS-1];
   assign p        = acc_ff[NS-1][2*W-1:0];
   assign side_out = side_ff[NS-1];

endmodule

// ----- hdl/lld_front.sv -----
// ----------------------------------------------------------------------------
// lld_front: front end of the distance engine
// Forms w, n = da x db, c = w x db and the squared norms, classifies the
// line pair against the threshold and emits num/den for the root unit.
// ----------------------------------------------------------------------------
module lld_front #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  lld_pkg::lld_req_type       req,
   input  logic [lld_pkg::THR_W-1:0]  thr,
   input  logic                       fifo_full,
   output logic                       busy,
   output logic                       job_valid,
   output lld_pkg::lld_job_type       job
);
   import lld_pkg::*;

   localparam int LIM_W = THR_W + 3 * COORD_FRAC_BITS;
   localparam int CMP_W = (LIM_W > DEN_W) ? LIM_W : DEN_W;
   localparam int M1_SW = 1 + MAG_W + 3;
   localparam int M2_SW = 2 + DEN_W + CNUM_W;

   logic adv;
   logic m2_v;

   // whole front advances together; it only halts when the queue is full
   assign adv       = !(m2_v && fifo_full);
   assign busy      = !adv;
   assign job_valid = m2_v && !fifo_full;

   // ---- input register
   logic        v0_ff;
   lld_req_type r0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && start) begin
         r0_ff <= req;
      end
   end

   // ---- products
   logic signed [COORD_W-1:0] da [3];
   logic signed [COORD_W-1:0] db [3];
   logic signed [COORD_W:0]   w   [3];
   logic signed [63:0] pn_in [6];
   logic signed [63:0] pc_in [6];
   logic signed [63:0] pd_in [3];
   logic signed [63:0] pq_in [3];

   always_comb begin
      da[0] = r0_ff.da_x;
      da[1] = r0_ff.da_y;
      da[2] = r0_ff.da_z;
      db[0] = r0_ff.db_x;
      db[1] = r0_ff.db_y;
      db[2] = r0_ff.db_z;
      w[0]  = {r0_ff.pa_x[COORD_W-1], r0_ff.pa_x} - {r0_ff.pb_x[COORD_W-1], r0_ff.pb_x};
      w[1]  = {r0_ff.pa_y[COORD_W-1], r0_ff.pa_y} - {r0_ff.pb_y[COORD_W-1], r0_ff.pb_y};
      w[2]  = {r0_ff.pa_z[COORD_W-1], r0_ff.pa_z} - {r0_ff.pb_z[COORD_W-1], r0_ff.pb_z};

      pn_in[0] = da[1] * db[2];
      pn_in[1] = da[2] * db[1];
      pn_in[2] = da[2] * db[0];
      pn_in[3] = da[0] * db[2];
      pn_in[4] = da[0] * db[1];
      pn_in[5] = da[1] * db[0];

      pc_in[0] = w[1] * db[2];
      pc_in[1] = w[2] * db[1];
      pc_in[2] = w[2] * db[0];
      pc_in[3] = w[0] * db[2];
      pc_in[4] = w[0] * db[1];
      pc_in[5] = w[1] * db[0];

      for (int i = 0; i < 3; i++) begin
         pd_in[i] = da[i] * db[i];
         pq_in[i] = db[i] * db[i];
      end
   end

   logic                     v1_ff;
   logic signed [63:0]       pn_ff [6];
   logic signed [63:0]       pc_ff [6];
   logic signed [63:0]       pd_ff [3];
   logic signed [63:0]       pq_ff [3];
   logic signed [COORD_W:0]  w1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pn_ff <= pn_in;
         pc_ff <= pc_in;
         pd_ff <= pd_in;
         pq_ff <= pq_in;
         w1_ff <= w;
      end
   end

   // ---- vector sums and magnitudes
   logic signed [64:0] n_s   [3];
   logic signed [64:0] c_s   [3];
   logic [64:0]        n_abs [3];
   logic [64:0]        c_abs [3];
   logic [COORD_W:0]   w_abs [3];
   logic [2:0]         sgn_in;
   logic signed [65:0] dsum;
   logic [MAG_W-1:0]   qsum;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_s[i]   = {pn_ff[2*i][63], pn_ff[2*i]} - {pn_ff[2*i+1][63], pn_ff[2*i+1]};
         c_s[i]   = {pc_ff[2*i][63], pc_ff[2*i]} - {pc_ff[2*i+1][63], pc_ff[2*i+1]};
         n_abs[i] = n_s[i][64] ? 65'(-n_s[i]) : 65'(n_s[i]);
         c_abs[i] = c_s[i][64] ? 65'(-c_s[i]) : 65'(c_s[i]);
         w_abs[i] = w1_ff[i][COORD_W] ? 33'(-w1_ff[i]) : 33'(w1_ff[i]);
         sgn_in[i] = w1_ff[i][COORD_W] ^ n_s[i][64];
      end
      dsum = 66'(pd_ff[0]) + 66'(pd_ff[1]) + 66'(pd_ff[2]);
      qsum = MAG_W'(pq_ff[0]) + MAG_W'(pq_ff[1]) + MAG_W'(pq_ff[2]);
   end

   logic              v2_ff;
   logic [MAG_W-1:0]  nmag2_ff [3];
   logic [MAG_W-1:0]  cmag2_ff [3];
   logic [WMAG_W-1:0] wmag2_ff [3];
   logic [2:0]        sgn2_ff;
   logic              dz2_ff;
   logic [MAG_W-1:0]  dbsq2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            nmag2_ff[i] <= n_abs[i][MAG_W-1:0];
            cmag2_ff[i] <= c_abs[i][MAG_W-1:0];
            wmag2_ff[i] <= w_abs[i];
         end
         sgn2_ff  <= sgn_in;
         dz2_ff   <= (dsum == '0);
         dbsq2_ff <= qsum;
      end
   end

   // ---- first multiplier bank: n_i^2, c_i^2, |w_i||n_i|
   logic [2*MAG_W-1:0] nsq [3];
   logic [2*MAG_W-1:0] csq [3];
   logic [2*MAG_W-1:0] wn  [3];
   logic               m1_v;
   logic [M1_SW-1:0]   m1_side;

   for (genvar i = 0; i < 3; i++) begin : g_m1
      if (i == 0) begin : g_carry
         lld_mul #(.W(MAG_W), .SW(M1_SW)) u_nsq (
            .clock(clock), .reset(reset), .en(adv), .in_v(v2_ff),
            .a(nmag2_ff[i]), .b(nmag2_ff[i]), .side_in({dz2_ff, dbsq2_ff, sgn2_ff}),
            .out_v(m1_v), .p(nsq[i]), .side_out(m1_side));
      end else begin : g_plain
         lld_mul #(.W(MAG_W), .SW(1)) u_nsq (
            .clock(clock), .reset(reset), .en(adv), .in_v(v2_ff),
            .a(nmag2_ff[i]), .b(nmag2_ff[i]), .side_in(1'b0),
            .out_v(), .p(nsq[i]), .side_out());
      end
      lld_mul #(.W(MAG_W), .SW(1)) u_csq (
         .clock(clock), .reset(reset), .en(adv), .in_v(v2_ff),
         .a(cmag2_ff[i]), .b(cmag2_ff[i]), .side_in(1'b0),
         .out_v(), .p(csq[i]), .side_out());
      lld_mul #(.W(MAG_W), .SW(1)) u_wn (
         .clock(clock), .reset(reset), .en(adv), .in_v(v2_ff),
         .a(MAG_W'(wmag2_ff[i])), .b(nmag2_ff[i]), .side_in(1'b0),
         .out_v(), .p(wn[i]), .side_out());
   end

   // ---- sums after the first bank
   logic                    m1_dz;
   logic [MAG_W-1:0]        m1_dbsq;
   logic [2:0]              m1_sgn;
   logic signed [EMAG_W:0]  e_in;

   assign {m1_dz, m1_dbsq, m1_sgn} = m1_side;

   always_comb begin
      e_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (m1_sgn[i]) begin
            e_in = e_in - $signed({1'b0, wn[i][EMAG_W-1:0]});
         end else begin
            e_in = e_in + $signed({1'b0, wn[i][EMAG_W-1:0]});
         end
      end
   end

   logic                   v3_ff;
   logic [DEN_W-1:0]       nn3_ff;
   logic [CNUM_W-1:0]      cnum3_ff;
   logic signed [EMAG_W:0] e3_ff;
   logic                   dz3_ff;
   logic [MAG_W-1:0]       dbsq3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= m1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nn3_ff   <= DEN_W'(nsq[0]) + DEN_W'(nsq[1]) + DEN_W'(nsq[2]);
         cnum3_ff <= CNUM_W'(csq[0]) + CNUM_W'(csq[1]) + CNUM_W'(csq[2]);
         e3_ff    <= e_in;
         dz3_ff   <= m1_dz;
         dbsq3_ff <= m1_dbsq;
      end
   end

   // ---- classify: |n|^2 against threshold scaled to raw units
   logic [LIM_W-1:0]  lim;
   logic              par_in;
   logic [EMAG_W:0]   e_abs;

   assign lim    = {thr, {(3 * COORD_FRAC_BITS){1'b0}}};
   assign par_in = CMP_W'(nn3_ff) <= CMP_W'(lim);
   assign e_abs  = e3_ff[EMAG_W] ? (EMAG_W + 1)'(-e3_ff) : (EMAG_W + 1)'(e3_ff);

   logic              v4_ff;
   logic              par4_ff;
   logic              deg4_ff;
   logic [DEN_W-1:0]  den4_ff;
   logic [CNUM_W-1:0] cnum4_ff;
   logic [EMAG_W-1:0] emag4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par4_ff  <= par_in;
         deg4_ff  <= par_in && dz3_ff;
         den4_ff  <= par_in ? DEN_W'(dbsq3_ff) : nn3_ff;
         cnum4_ff <= cnum3_ff;
         emag4_ff <= e_abs[EMAG_W-1:0];
      end
   end

   // ---- second multiplier: (w.n)^2
   logic [NUM_W-1:0]  e2;
   logic [M2_SW-1:0]  m2_side;
   logic              m2_par;
   logic              m2_deg;
   logic [DEN_W-1:0]  m2_den;
   logic [CNUM_W-1:0] m2_cnum;

   lld_mul #(.W(EMAG_W), .SW(M2_SW)) u_esq (
      .clock(clock), .reset(reset), .en(adv), .in_v(v4_ff),
      .a(emag4_ff), .b(emag4_ff), .side_in({par4_ff, deg4_ff, den4_ff, cnum4_ff}),
      .out_v(m2_v), .p(e2), .side_out(m2_side));

   assign {m2_par, m2_deg, m2_den, m2_cnum} = m2_side;

   // degenerate: num 0 over den 1 makes the root come out as zero
   always_comb begin
      job.is_parallel = m2_par;
      job.degenerate  = m2_deg;
      if (m2_deg) begin
         job.num = '0;
         job.den = DEN_W'(1);
      end else begin
         job.num = m2_par ? NUM_W'(m2_cnum) : e2;
         job.den = m2_den;
      end
   end

endmodule

// ----- hdl/lld_fifo.sv -----
// ----------------------------------------------------------------------------
// lld_fifo: short job queue between front end and root unit
// ----------------------------------------------------------------------------
module lld_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lld_pkg::lld_job_type  wdata,
   input  logic                  pop,
   output logic                  full,
   output logic                  valid,
   output lld_pkg::lld_job_type  rdata
);
   import lld_pkg::*;

   lld_job_type      mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/lld_root.sv -----
// ----------------------------------------------------------------------------
// lld_root: pipelined root of a ratio
// One result bit per stage, MSB first: largest r with r^2 * den <= num.
// Keeps rem = num - r^2*den and q = r*den so each stage is an add and compare.
// ----------------------------------------------------------------------------
module lld_root (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_v,
   input  lld_pkg::lld_job_type        job,
   output logic                        rsp_strobe,
   output logic [lld_pkg::DIST_W-1:0]  rsp_distance,
   output logic                        rsp_is_parallel,
   output logic                        rsp_degenerate
);
   import lld_pkg::*;

   localparam int NS = DIST_W + 1;

   logic              v_ff    [NS];
   logic [NUM_W-1:0]  rem_ff  [NS];
   logic [Q_W-1:0]    q_ff    [NS];
   logic [DIST_W-1:0] r_ff    [NS];
   logic [DEN_W-1:0]  den_ff  [NS];
   logic [1:0]        flag_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= job_v;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= job.num;
      q_ff[0]    <= '0;
      r_ff[0]    <= '0;
      den_ff[0]  <= job.den;
      flag_ff[0] <= {job.is_parallel, job.degenerate};
   end

   for (genvar s = 0; s < DIST_W; s++) begin : g_bit
      localparam int K = DIST_W - 1 - s;
      logic [T_W-1:0] trial;
      logic           fit;

      // (r + 2^K)^2 den - r^2 den = q*2^(K+1) + den*2^(2K)
      assign trial = (T_W'(q_ff[s]) << (K + 1)) + (T_W'(den_ff[s]) << (2 * K));
      assign fit   = trial <= T_W'(rem_ff[s]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= fit ? rem_ff[s] - trial[NUM_W-1:0] : rem_ff[s];
         q_ff[s+1]    <= fit ? q_ff[s] + (Q_W'(den_ff[s]) << K) : q_ff[s];
         r_ff[s+1]    <= r_ff[s] | (DIST_W'(fit) << K);
         den_ff[s+1]  <= den_ff[s];
         flag_ff[s+1] <= flag_ff[s];
      end
   end

   assign rsp_strobe      = v_ff[NS-1];
   assign rsp_distance    = r_ff[NS-1];
   assign rsp_is_parallel = flag_ff[NS-1][1];
   assign rsp_degenerate  = flag_ff[NS-1][0];

endmodule

// ----- hdl/lld_check.sv -----
// ----------------------------------------------------------------------------
// lld_check: port-level checks for the line distance engine
// ----------------------------------------------------------------------------
module lld_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [lld_pkg::CSR_AW-1:0]    paddr,
   input logic [lld_pkg::CSR_DW-1:0]    pwdata,
   input logic [lld_pkg::CSR_DW-1:0]    prdata,
   input logic                          rsp_strobe,
   input logic [lld_pkg::DIST_W-1:0]    rsp_distance,
   input logic                          rsp_is_parallel,
   input logic                          rsp_degenerate
);
   import lld_pkg::*;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |-> rsp_is_parallel && (rsp_distance == '0))
      else $error("degenerate result not parallel or nonzero");

   a_nonpar_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_parallel |-> !rsp_degenerate)
      else $error("degenerate flag on general-case result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_thr_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[CSR_AW-1] == CSR_IDX_THR)) ##1
      (psel && !pwrite && (paddr[CSR_AW-1] == CSR_IDX_THR))
      |-> prdata == CSR_DW'($past(pwdata[THR_W-1:0])))
      else $error("threshold readback mismatch");

endmodule

bind line_line_distance_3d lld_check u_check (
   .clock           (clock),
   .reset           (reset),
   .psel            (psel),
   .penable         (penable),
   .pwrite          (pwrite),
   .paddr           (paddr),
   .pwdata          (pwdata),
   .prdata          (prdata),
   .rsp_strobe      (rsp_strobe),
   .rsp_distance    (rsp_distance),
   .rsp_is_parallel (rsp_is_parallel),
   .rsp_degenerate  (rsp_degenerate)
);
